>>> hw/rtl/text_console_cell_engine_assert.svh
// ----------------------------------------------------------------------------
// text_console_cell_engine_assert.svh
// Assertion macros used by the console engine back end.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// same-cycle implication
`define TCCE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and helpers of the text console cell engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 30;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CUR_W  = $clog2(COLS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CH_W   = 8;
    localparam int CLR_W  = 4;
    localparam int CELL_W = 16;

    localparam logic [CH_W-1:0]   CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0]   CH_NL      = 8'h0A;
    localparam logic [CH_W-1:0]   CH_CURSOR  = 8'h5F;
    localparam logic [CLR_W-1:0]  WHITE      = 4'hF;
    localparam logic [CLR_W-1:0]  BLACK      = 4'h0;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h20F0;
    localparam logic [7:0]        BLINK_RST  = 8'd20;

    localparam logic CFG_IDX_MUTE  = 1'b0;
    localparam logic CFG_IDX_BLINK = 1'b1;

    typedef enum logic [2:0] {
        CMD_PUT     = 3'd0,
        CMD_BS      = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_CLR_CUR = 3'd3,
        CMD_CLR_SCR = 3'd4,
        CMD_SET_BG  = 3'd5,
        CMD_READ    = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_BS,
        OP_TICK,
        OP_CLR_CUR,
        OP_CLR_SCR,
        OP_SET_BG,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        KIND_DRAW   = 2'd0,
        KIND_REDRAW = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_COPY,
        S_COPY_FLUSH,
        S_RECOLOR,
        S_RECOLOR_FLUSH,
        S_WRITE,
        S_READ
    } st_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  ch;
        logic [CLR_W-1:0] fg;
        logic [CLR_W-1:0] bg;
        logic [COL_W-1:0] rc;
        logic [ROW_W-1:0] rr;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } fq_t;

    typedef struct packed {
        logic pop;
        logic init_done;
    } bk_ctl_t;

    typedef struct packed {
        kind_t            kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CH_W-1:0]  glyph;
        logic [CLR_W-1:0] fg;
        logic [CLR_W-1:0] bg;
        logic             last;
    } res_t;

    typedef struct packed {
        logic       blink_mute;
        logic [7:0] blink_period;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                    input logic [CUR_W-1:0] c);
        cell_addr = ADDR_W'(32'(r) * COLS + 32'(c));
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [COL_W-1:0] c,
                                    input logic [ROW_W-1:0] r, input logic [CH_W-1:0] g,
                                    input logic [CLR_W-1:0] f, input logic [CLR_W-1:0] b);
        mk_res = '{kind: k, col: c, row: r, glyph: g, fg: f, bg: b, last: 1'b0};
    endfunction

endpackage

>>> hw/rtl/tcce_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_chan_if
// Command and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface tcce_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  cmd;
    logic [tcce_pkg::CH_W-1:0]   char_code;
    logic [tcce_pkg::CLR_W-1:0]  fg_in;
    logic [tcce_pkg::CLR_W-1:0]  bg_in;
    logic [tcce_pkg::COL_W-1:0]  read_col;
    logic [tcce_pkg::ROW_W-1:0]  read_row;

    modport source (output valid, cmd, char_code, fg_in, bg_in, read_col, read_row,
                    input ready);
    modport sink (input valid, cmd, char_code, fg_in, bg_in, read_col, read_row,
                  output ready);
endinterface

interface tcce_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [tcce_pkg::COL_W-1:0]  col;
    logic [tcce_pkg::ROW_W-1:0]  row;
    logic [tcce_pkg::CH_W-1:0]   glyph;
    logic [tcce_pkg::CLR_W-1:0]  fg_out;
    logic [tcce_pkg::CLR_W-1:0]  bg_out;
    logic                        last;

    modport source (output valid, kind, col, row, glyph, fg_out, bg_out, last,
                    input ready);
    modport sink (input valid, kind, col, row, glyph, fg_out, bg_out, last,
                  output ready);
endinterface

>>> hw/rtl/tcce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic              clk,
    input  logic              rst_n,
    tcce_cmd_if.sink          cmd_ch,
    input  tcce_pkg::bk_ctl_t bk,
    output tcce_pkg::fq_t     fq
);
    import tcce_pkg::*;

    item_t      slot_reg [2];
    item_t      slot_next [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic       push;

    // classify
    always_comb
    begin
        cls    = '{op: OP_NOP, ch: cmd_ch.char_code, fg: cmd_ch.fg_in, bg: cmd_ch.bg_in,
                   rc: cmd_ch.read_col, rr: cmd_ch.read_row};
        case (cmd_t'(cmd_ch.cmd))
            CMD_PUT:     cls.op = (cmd_ch.char_code == CH_NL) ? OP_NEWLINE : OP_PUT;
            CMD_BS:      cls.op = OP_BS;
            CMD_TICK:    cls.op = OP_TICK;
            CMD_CLR_CUR: cls.op = OP_CLR_CUR;
            CMD_CLR_SCR: cls.op = OP_CLR_SCR;
            CMD_SET_BG:  cls.op = OP_SET_BG;
            CMD_READ:    cls.op = OP_READ;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign cmd_ch.ready = (cnt_reg != 2'd2) && bk.init_done;
    assign push         = cmd_ch.valid && cmd_ch.ready;
    assign fq.valid     = (cnt_reg != 2'd0);
    assign fq.item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        slot_next   = slot_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            slot_next[wr_ptr_reg] = cls;
            wr_ptr_next           = ~wr_ptr_reg;
        end
        if (bk.pop)
            rd_ptr_next = ~rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, bk.pop};
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/tcce_back.sv
`timescale 1ns / 1ps
`include "text_console_cell_engine_assert.svh"
// ----------------------------------------------------------------------------
// tcce_back
// Executes queued commands: cursor, blink timer, cell store sweeps, results.
// ----------------------------------------------------------------------------
module tcce_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tcce_pkg::cfg_t    cfg,
    input  tcce_pkg::fq_t     fq,
    output tcce_pkg::bk_ctl_t bk,
    tcce_res_if.source        res_ch
);
    import tcce_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LROW_ADDR = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [CUR_W-1:0]  COLS_C    = CUR_W'(COLS);
    localparam logic [RW-1:0]     LROW_R    = RW'(ROWS - 1);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [CELL_W-1:0] mem_wd;

    st_t               state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              init_done_reg, init_done_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0] wr_data_reg, wr_data_next;
    logic [CUR_W-1:0]  col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              blink_reg, blink_next;
    logic [7:0]        phase_reg, phase_next;
    logic [CLR_W-1:0]  cbg_reg, cbg_next;
    res_t              res_reg [3];
    res_t              res_next [3];
    logic [1:0]        res_cnt_reg, res_cnt_next;
    logic [1:0]        res_idx_reg, res_idx_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg, out_data_next;

    // dispatch decode
    res_t              d_list [3];
    logic [1:0]        d_n;
    st_t               d_target;
    logic [ADDR_W-1:0] d_cnt;
    logic              d_we;
    logic [ADDR_W-1:0] d_wa, d_ra, d_wr_addr;
    logic [CELL_W-1:0] d_wd, d_wr_data;
    logic              d_wr_pend;
    logic [CUR_W-1:0]  d_col, pc;
    logic [RW-1:0]     d_row, pr;
    logic              d_blink;
    logic [7:0]        d_phase, d_tick;
    logic [CLR_W-1:0]  d_cbg;

    logic pop, emit, recolor;

    assign pop  = (state_reg == S_IDLE) && fq.valid && (res_idx_reg == res_cnt_reg);
    assign emit = (state_reg == S_IDLE) && (res_idx_reg != res_cnt_reg)
                  && (!out_valid_reg || res_ch.ready);
    assign recolor = (state_reg == S_RECOLOR) || (state_reg == S_RECOLOR_FLUSH);

    assign bk.pop       = pop;
    assign bk.init_done = init_done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_list[i] = '0;
        d_n       = 2'd0;
        d_target  = S_IDLE;
        d_cnt     = cnt_reg;
        d_we      = 1'b0;
        d_wa      = '0;
        d_wd      = BLANK_CELL;
        d_ra      = '0;
        d_wr_pend = wr_pend_reg;
        d_wr_addr = wr_addr_reg;
        d_wr_data = wr_data_reg;
        d_col     = col_reg;
        d_row     = row_reg;
        d_blink   = blink_reg;
        d_phase   = phase_reg;
        d_cbg     = cbg_reg;
        d_tick    = phase_reg + 8'd1;
        pc        = col_reg;
        pr        = row_reg;
        case (fq.item.op)
            OP_NEWLINE:
            begin
                d_col = '0;
                if (row_reg == LROW_R)
                begin
                    d_target  = S_COPY;
                    d_cnt     = ROW1_ADDR;
                    d_list[0] = mk_res(KIND_REDRAW, '0, '0, '0, '0, '0);
                    d_n       = 2'd1;
                end
                else
                    d_row = row_reg + RW'(1);
            end
            OP_PUT:
            begin
                if (col_reg >= COLS_C)
                begin
                    pc = '0;
                    if (row_reg == LROW_R)
                    begin
                        d_target  = S_COPY;
                        d_cnt     = ROW1_ADDR;
                        d_wr_pend = 1'b1;
                        d_list[0] = mk_res(KIND_REDRAW, '0, '0, '0, '0, '0);
                        d_n       = 2'd1;
                    end
                    else
                        pr = row_reg + RW'(1);
                end
                d_wr_addr = cell_addr(pr, pc);
                d_wr_data = {fq.item.ch, fq.item.fg, fq.item.bg};
                if (d_n == 2'd0)
                begin
                    d_we = 1'b1;
                    d_wa = d_wr_addr;
                    d_wd = d_wr_data;
                end
                d_list[d_n] = mk_res(KIND_DRAW, COL_W'(pc), ROW_W'(pr), fq.item.ch,
                                     fq.item.fg, fq.item.bg);
                d_n   = d_n + 2'd1;
                d_col = pc + CUR_W'(1);
                d_row = pr;
            end
            OP_BS:
            begin
                if (col_reg != '0 || row_reg != '0)
                begin
                    if (col_reg < COLS_C)
                    begin
                        d_list[d_n] = mk_res(KIND_DRAW, COL_W'(col_reg), ROW_W'(row_reg),
                                             CH_SPACE, WHITE, cbg_reg);
                        d_n = d_n + 2'd1;
                    end
                    if (col_reg != '0)
                        pc = col_reg - CUR_W'(1);
                    else
                    begin
                        pc = COLS_C - CUR_W'(1);
                        pr = row_reg - RW'(1);
                    end
                    d_list[d_n] = mk_res(KIND_DRAW, COL_W'(pc), ROW_W'(pr), CH_SPACE,
                                         cbg_reg, cbg_reg);
                    d_n = d_n + 2'd1;
                    if (blink_reg)
                    begin
                        d_list[d_n] = mk_res(KIND_DRAW, COL_W'(pc), ROW_W'(pr), CH_CURSOR,
                                             WHITE, cbg_reg);
                        d_n = d_n + 2'd1;
                    end
                    d_col = pc;
                    d_row = pr;
                end
            end
            OP_TICK:
            begin
                d_phase = d_tick;
                if (d_tick == cfg.blink_period)
                begin
                    d_phase = 8'd0;
                    if (!cfg.blink_mute)
                    begin
                        d_blink = ~blink_reg;
                        if (col_reg < COLS_C)
                        begin
                            d_list[0] = mk_res(KIND_DRAW, COL_W'(col_reg), ROW_W'(row_reg),
                                               d_blink ? CH_CURSOR : CH_SPACE, WHITE, BLACK);
                            d_n = 2'd1;
                        end
                    end
                end
            end
            OP_CLR_CUR:
            begin
                d_blink = 1'b0;
                if (col_reg < COLS_C)
                begin
                    d_list[0] = mk_res(KIND_DRAW, COL_W'(col_reg), ROW_W'(row_reg), CH_SPACE,
                                       cbg_reg, cbg_reg);
                    d_n = 2'd1;
                end
            end
            OP_CLR_SCR:
            begin
                d_col     = '0;
                d_row     = '0;
                d_target  = S_FILL;
                d_cnt     = '0;
                d_list[0] = mk_res(KIND_REDRAW, '0, '0, '0, '0, '0);
                d_n       = 2'd1;
            end
            OP_SET_BG:
            begin
                d_cbg     = fq.item.bg;
                d_target  = S_RECOLOR;
                d_cnt     = '0;
                d_list[0] = mk_res(KIND_REDRAW, '0, '0, '0, '0, '0);
                d_n       = 2'd1;
            end
            OP_READ:
            begin
                d_list[0] = mk_res(KIND_READ, fq.item.rc, fq.item.rr, '0, '0, '0);
                d_n       = 2'd1;
                if (32'(fq.item.rc) < COLS && 32'(fq.item.rr) < ROWS)
                begin
                    d_ra     = cell_addr(RW'(fq.item.rr), CUR_W'(fq.item.rc));
                    d_target = S_READ;
                end
            end
            default:
            begin
                d_n = 2'd0;
            end
        endcase
        if (d_n != 2'd0)
            d_list[d_n - 2'd1].last = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (pop)
                    state_next = d_target;
            S_FILL:
                if (cnt_reg == LAST_ADDR)
                    state_next = wr_pend_reg ? S_WRITE : S_IDLE;
            S_COPY:
                if (cnt_reg == LAST_ADDR)
                    state_next = S_COPY_FLUSH;
            S_COPY_FLUSH:
                state_next = S_FILL;
            S_RECOLOR:
                if (cnt_reg == LAST_ADDR)
                    state_next = S_RECOLOR_FLUSH;
            S_RECOLOR_FLUSH:
                state_next = S_IDLE;
            S_WRITE:
                state_next = S_IDLE;
            S_READ:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next        = cnt_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        init_done_next  = init_done_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        blink_next      = blink_reg;
        phase_next      = phase_reg;
        cbg_next        = cbg_reg;
        res_next        = res_reg;
        res_cnt_next    = res_cnt_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_wa          = cnt_reg;
        mem_wd          = BLANK_CELL;
        mem_ra          = cnt_reg;

        if (pend_valid_reg)
        begin
            mem_we = 1'b1;
            mem_wa = pend_addr_reg;
            mem_wd = recolor ? {rd_data_reg[CELL_W-1:CLR_W], cbg_reg} : rd_data_reg;
        end

        if (out_valid_reg && res_ch.ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg[res_idx_reg];
            res_idx_next   = res_idx_reg + 2'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                mem_ra = d_ra;
                if (pop)
                begin
                    mem_we       = d_we;
                    mem_wa       = d_wa;
                    mem_wd       = d_wd;
                    cnt_next     = d_cnt;
                    wr_pend_next = d_wr_pend;
                    wr_addr_next = d_wr_addr;
                    wr_data_next = d_wr_data;
                    col_next     = d_col;
                    row_next     = d_row;
                    blink_next   = d_blink;
                    phase_next   = d_phase;
                    cbg_next     = d_cbg;
                    res_next     = d_list;
                    res_cnt_next = d_n;
                    res_idx_next = 2'd0;
                end
            end
            S_FILL:
            begin
                mem_we   = 1'b1;
                mem_wa   = cnt_reg;
                mem_wd   = BLANK_CELL;
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_ADDR)
                    init_done_next = 1'b1;
            end
            S_COPY:
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg - ROW1_ADDR;
                cnt_next        = cnt_reg + ADDR_W'(1);
            end
            S_COPY_FLUSH:
                cnt_next = LROW_ADDR;
            S_RECOLOR:
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg;
                cnt_next        = cnt_reg + ADDR_W'(1);
            end
            S_WRITE:
            begin
                mem_we       = 1'b1;
                mem_wa       = wr_addr_reg;
                mem_wd       = wr_data_reg;
                wr_pend_next = 1'b0;
            end
            S_READ:
            begin
                res_next[0].glyph = rd_data_reg[CELL_W-1:CELL_W-CH_W];
                res_next[0].fg    = rd_data_reg[2*CLR_W-1:CLR_W];
                res_next[0].bg    = rd_data_reg[CLR_W-1:0];
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign res_ch.valid  = out_valid_reg;
    assign res_ch.kind   = out_data_reg.kind;
    assign res_ch.col    = out_data_reg.col;
    assign res_ch.row    = out_data_reg.row;
    assign res_ch.glyph  = out_data_reg.glyph;
    assign res_ch.fg_out = out_data_reg.fg;
    assign res_ch.bg_out = out_data_reg.bg;
    assign res_ch.last   = out_data_reg.last;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        wr_addr_reg   <= wr_addr_next;
        wr_data_reg   <= wr_data_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            init_done_reg  <= 1'b0;
            wr_pend_reg    <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            blink_reg      <= 1'b0;
            phase_reg      <= 8'd0;
            cbg_reg        <= BLACK;
            res_cnt_reg    <= 2'd0;
            res_idx_reg    <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            init_done_reg  <= init_done_next;
            wr_pend_reg    <= wr_pend_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            blink_reg      <= blink_next;
            phase_reg      <= phase_next;
            cbg_reg        <= cbg_next;
            res_cnt_reg    <= res_cnt_next;
            res_idx_reg    <= res_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `TCCE_ASSERT(a_res_idx_bound, 1'b1, res_idx_reg <= res_cnt_reg, "result index overran")
    `TCCE_ASSERT(a_no_pop_in_init, !init_done_reg, !pop, "dispatch before clearing pass")
    `TCCE_ASSERT_NEXT(a_copy_flow, state_reg == S_COPY,
        state_reg == S_COPY || state_reg == S_COPY_FLUSH, "scroll copy left early")
    `TCCE_ASSERT(a_emit_idle, emit, state_reg == S_IDLE, "result sent during sweep")

endmodule

>>> hw/rtl/text_console_cell_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_engine
// Character-cell console: cell store, cursor, blink timer and redraw results.
// ----------------------------------------------------------------------------
// Commands enter on cmd_ch (valid/ready); each transfer gives zero to three
// results on res_ch, the final one marked by last. Configuration is written
// through cfg_we / cfg_index / cfg_data by the user while the block is idle;
// the block itself does not enforce this. A two-entry command queue parts the
// front end from the executor, and a result register parts the executor from
// res_ch. The executor dispatches a command and then passes its results one
// at a time to the result register; it takes the next command only once all
// results of the last one are sent. A scroll copies ROWS-1 rows up and then
// fills the last row; clear screen and set background sweep every cell. The
// sweeps use the single write port of the cell store, one cell a cycle.
// A read command takes its cell from the registered store read.
// A stalled receiver holds the executor once the result register is full and
// another result waits; cmd_ch.ready drops once the queue fills behind it.
// After reset the store is swept to white-on-black spaces over all ROWS*COLS
// cells; cmd_ch.ready stays low until then. Results are released only while
// the executor is not sweeping.
// ----------------------------------------------------------------------------
module text_console_cell_engine (
    input  logic       clk,
    input  logic       rst_n,
    tcce_cmd_if.sink   cmd_ch,
    tcce_res_if.source res_ch,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import tcce_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    fq_t     fq;
    bk_ctl_t bk;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_MUTE:  cfg_next.blink_mute   = cfg_data[0];
                CFG_IDX_BLINK: cfg_next.blink_period = cfg_data;
                default:       cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{blink_mute: 1'b0, blink_period: BLINK_RST};
        else
            cfg_reg <= cfg_next;
    end

    tcce_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .bk     (bk),
        .fq     (fq)
    );

    tcce_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fq     (fq),
        .bk     (bk),
        .res_ch (res_ch)
    );

endmodule
